// ===== sv/crsc_pkg.sv =====
`timescale 1ns / 1ps

package crsc_pkg;

    // Status codes carried with every result.
    localparam logic [2:0] ST_PASS  = 3'd0;
    localparam logic [2:0] ST_OK    = 3'd1;
    localparam logic [2:0] ST_SHORT = 3'd2;
    localparam logic [2:0] ST_MAGIC = 3'd3;
    localparam logic [2:0] ST_CRC   = 3'd4;

    localparam logic [7:0]  MAGIC_EVEN = 8'hAA;
    localparam logic [7:0]  MAGIC_ODD  = 8'h55;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [2:0]  MIN_LEN    = 3'd6;

    // Results one input byte can cause, and the depth of the result queue.
    localparam int MAX_RES = 3;
    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       record_end;
    } t_result;

    // Results produced by one accepted byte, slot 0 goes out first.
    typedef struct packed {
        logic [1:0]                 count;
        t_result [MAX_RES-1:0]      slot;
    } t_push;

    // One byte of CRC-16/MODBUS, reflected, LSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/crsc_core.sv =====
`timescale 1ns / 1ps

module crsc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_seal_mode,
    input  logic           i_valid,
    input  logic [7:0]     i_data_byte,
    input  logic           i_final_byte,
    output crsc_pkg::t_push o_push
);
    import crsc_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic [2:0]  r_byte_count, n_byte_count;
    logic        r_magic_match, n_magic_match;
    logic [7:0]  r_held [0:1];

    logic [7:0]  magic_exp;
    logic [7:0]  leave_byte;
    logic [15:0] crc_upd;
    logic [15:0] stored_crc;
    logic        leaving;
    logic        short_rec;
    logic        clear;
    t_push       push;

    assign magic_exp  = r_byte_count[0] ? MAGIC_ODD : MAGIC_EVEN;
    assign leaving    = r_byte_count >= 3'd2;
    assign short_rec  = i_final_byte && (r_byte_count < (MIN_LEN - 3'd1));
    // While the magic word is still leaving the delay line, seal mode
    // replaces it; the parity of the leaving position equals that of the count.
    assign leave_byte = (i_seal_mode && (r_byte_count < MIN_LEN)) ? magic_exp : r_held[0];
    assign crc_upd    = crc_feed(r_crc, leave_byte);
    assign stored_crc = {i_data_byte, r_held[1]};
    assign clear      = i_final_byte;

    always_comb begin
        push          = '0;
        n_crc         = r_crc;
        n_byte_count  = r_byte_count;
        n_magic_match = r_magic_match;
        if ((r_byte_count < 3'd4) && (i_data_byte != magic_exp)) begin
            n_magic_match = 1'b0;
        end
        if (leaving) begin
            n_crc = crc_upd;
        end
        if (short_rec) begin
            push.count   = 2'd1;
            push.slot[0] = '{out_byte: 8'h00, status: ST_SHORT, record_end: 1'b1};
        end else if (i_final_byte) begin
            if (i_seal_mode) begin
                push.count   = 2'd3;
                push.slot[0] = '{out_byte: leave_byte, status: ST_PASS, record_end: 1'b0};
                push.slot[1] = '{out_byte: crc_upd[7:0], status: ST_PASS, record_end: 1'b0};
                push.slot[2] = '{out_byte: crc_upd[15:8], status: ST_OK, record_end: 1'b1};
            end else begin
                push.count   = 2'd1;
                push.slot[0].record_end = 1'b1;
                if (!n_magic_match) begin
                    push.slot[0].status = ST_MAGIC;
                end else if (stored_crc != crc_upd) begin
                    push.slot[0].status = ST_CRC;
                end else begin
                    push.slot[0].status = ST_OK;
                end
            end
        end else begin
            if (leaving && i_seal_mode) begin
                push.count   = 2'd1;
                push.slot[0] = '{out_byte: leave_byte, status: ST_PASS, record_end: 1'b0};
            end
            if (r_byte_count < MIN_LEN) begin
                n_byte_count = r_byte_count + 3'd1;
            end
        end
        if (clear) begin
            n_crc         = CRC_INIT;
            n_byte_count  = 3'd0;
            n_magic_match = 1'b1;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc         <= CRC_INIT;
            r_byte_count  <= 3'd0;
            r_magic_match <= 1'b1;
        end else if (i_valid) begin
            r_crc         <= n_crc;
            r_byte_count  <= n_byte_count;
            r_magic_match <= n_magic_match;
        end
    end

    // Two-byte delay line; every entry is written before it is read.
    always_ff @(posedge i_clk) begin
        if (i_valid && !i_final_byte) begin
            r_held[0] <= r_held[1];
            r_held[1] <= i_data_byte;
        end
    end

endmodule

// ===== sv/crsc_outq.sv =====
`timescale 1ns / 1ps

module crsc_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_en,
    input  crsc_pkg::t_push     i_push,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output crsc_pkg::t_result   o_result
);
    import crsc_pkg::*;

    t_result           r_mem [0:QDEPTH-1];
    logic [QAW-1:0]    r_wp, n_wp;
    logic [QAW-1:0]    r_rp, n_rp;
    logic [QCW-1:0]    r_count, n_count;
    logic [1:0]        push_n;
    logic              pop;

    assign push_n   = i_push_en ? i_push.count : 2'd0;
    assign pop      = o_valid && i_ready;
    assign o_valid  = r_count != '0;
    assign o_result = r_mem[r_rp];
    // Room for the largest burst one byte can cause.
    assign o_space  = r_count <= QCW'(QDEPTH - MAX_RES);

    always_comb begin
        n_wp    = r_wp + QAW'(push_n);
        n_rp    = r_rp + QAW'(pop);
        n_count = r_count + QCW'(push_n) - QCW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < push_n) begin
                r_mem[r_wp + QAW'(k)] <= i_push.slot[k];
            end
        end
    end

endmodule

// ===== sv/config_record_seal_and_check.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Transfer   Fields (low bit up)
// s_axis    in   one byte   tdata: data_byte[7:0]; tlast: final_byte
// m_axis    out  one result tdata: out_byte[7:0]; tuser: status[2:0]; tlast: record_end
// cfg       in   register   i_cfg_data: seal_mode
//
// Each byte is processed in the cycle it is transferred; its results enter a
// four-entry result queue and appear on m_axis from the next cycle on.
// One byte per cycle is sustained while m_axis drains; the last byte of a
// sealed record puts three results in the queue, so s_axis_tready stays low
// until the queue has drained to one result.
// s_axis_tready depends only on queue fill, so an m_axis stall holds the input.
// Reset is synchronous and active low and clears the record state and mode.

module config_record_seal_and_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte[7:0]
    output logic [2:0] m_axis_tuser,   // status[2:0]
    output logic       m_axis_tlast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data      // seal_mode
);
    import crsc_pkg::*;

    logic    r_seal_mode;
    logic    in_xfer;
    logic    space;
    t_push   push;
    t_result result;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = space;
    assign in_xfer       = s_axis_tvalid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seal_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_seal_mode <= i_cfg_data;
        end
    end

    crsc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seal_mode  (r_seal_mode),
        .i_valid      (in_xfer),
        .i_data_byte  (s_axis_tdata),
        .i_final_byte (s_axis_tlast),
        .o_push       (push)
    );

    crsc_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (in_xfer),
        .i_push    (push),
        .o_space   (space),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (result)
    );

    assign m_axis_tdata = result.out_byte;
    assign m_axis_tuser = result.status;
    assign m_axis_tlast = result.record_end;

endmodule
